### design/dlo_pkg.sv
// shared types and codes for the dependency load order core
package dlo_pkg;

  typedef enum logic [1:0] {
    OP_BEGIN   = 2'd0,
    OP_LOAD    = 2'd1,
    OP_APPEND  = 2'd2,
    OP_REQUEST = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_INVALID      = 3'd1,
    ST_NOT_FOUND    = 3'd2,
    ST_CYCLE        = 3'd3,
    ST_FULL         = 3'd4,
    ST_BAD_INDEX    = 3'd5,
    ST_BATCH_FAILED = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    MARK_UNVISITED = 2'd0,
    MARK_VISITING  = 2'd1,
    MARK_DONE      = 2'd2
  } mark_e;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_SRCH_ADDR = 9'b000000010,
    S_SRCH_CMP  = 9'b000000100,
    S_VISIT     = 9'b000001000,
    S_LOOP      = 9'b000010000,
    S_TGT       = 9'b000100000,
    S_POP       = 9'b001000000,
    S_EMIT      = 9'b010000000,
    S_CLOSE     = 9'b100000000
  } state_e;

  localparam int unsigned NODE_W = 5;
  localparam int unsigned CNT_REG_W = 6;

endpackage

### design/dependency_load_order_core.sv
// dependency load order core: catalog, id search and depth-first post-order walk
//
// usage:
//   s_axis carries one command beat: tuser holds the operation (begin batch,
//   load asset id, append dependency, request asset), tdata holds entry index,
//   target index and asset id. m_axis returns result beats: one beat per
//   emitted entry (dependencies first), then one closing beat with tlast=1
//   that carries the status of the command.
//   cfg_we_i/cfg_wdata_i write entry_count; write only while the core is idle.
// sequencing:
//   begin/load/append: the core goes to the close state, which loads the
//   closing beat once the output register is free; the next command is taken
//   back in idle. a request searches the id table entry by entry (address,
//   then compare), then walks: visits entries, reads dependency edges, emits
//   each entry and pops its frame, then loads the closing beat; one registered
//   read port per memory sets the pace. s_axis_tready is high only in idle.
// reset:
//   clears entry_count, dependency counts, visit marks, the stack pointer and
//   the sticky batch error; id and target memories keep garbage until loaded.
// stall:
//   one output register holds a result beat; while it is full and m_axis_tready
//   is low, the walk pauses at its next emit or close until that beat is taken.
module dependency_load_order_core
  import dlo_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 32,
  parameter int unsigned MAX_DEPS    = 8,
  parameter int unsigned ID_BITS     = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] entry_index, [9:5] target_index, [41:10] asset_id, rest zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] order_entry, [5] has_entry, [8:6] status, rest zero
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int unsigned EIW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(MAX_DEPS + 1);
  localparam int unsigned TD   = MAX_ENTRIES * MAX_DEPS;
  localparam int unsigned AW   = (TD > 1) ? $clog2(TD) : 1;
  localparam int unsigned SPW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned FW   = NODE_W + CW;

  // command fields
  logic [NODE_W-1:0]  in_ei, in_ti;
  logic [63:0]        in_id_ext;
  logic [ID_BITS-1:0] in_id;
  op_e                in_op;
  logic               in_fire;

  assign in_ei     = s_axis_tdata[4:0];
  assign in_ti     = s_axis_tdata[9:5];
  assign in_id_ext = {32'b0, s_axis_tdata[41:10]};
  assign in_id     = in_id_ext[ID_BITS-1:0];
  assign in_op     = op_e'(s_axis_tuser);

  state_e state_q, state_d;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // entry_count register and active count
  logic [CNT_REG_W-1:0] entry_count_q;
  logic [CNT_REG_W-1:0] n_act;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end
  assign n_act = (32'(entry_count_q) > MAX_ENTRIES) ? CNT_REG_W'(MAX_ENTRIES)
                                                    : entry_count_q;

  // flop state
  logic [CW-1:0]      dep_cnt_q [MAX_ENTRIES];
  mark_e              marks_q   [MAX_ENTRIES];
  logic [SPW-1:0]     sp_q, sp_d;
  logic               failed_q, failed_d;
  logic [CNT_REG_W-1:0] idx_q, idx_d;
  logic [NODE_W-1:0]  vnode_q, vnode_d;
  logic [NODE_W-1:0]  top_node_q, top_node_d;
  logic [CW-1:0]      top_next_q, top_next_d;
  logic [ID_BITS-1:0] req_id_q, req_id_d;
  status_e            st_q, st_d;

  // id table memory
  logic [ID_BITS-1:0] id_mem [MAX_ENTRIES];
  logic [ID_BITS-1:0] id_rd_q;
  logic               id_we;
  logic [EIW-1:0]     id_raddr;
  // dependency target memory
  logic [NODE_W-1:0]  tgt_mem [TD];
  logic [NODE_W-1:0]  tgt_rd_q;
  logic               tgt_we, tgt_re;
  logic [AW-1:0]      tgt_waddr, tgt_raddr;
  // stack memory of frames below the top
  logic [FW-1:0]      stk_mem [MAX_ENTRIES];
  logic [FW-1:0]      stk_rd_q;
  logic               stk_we, stk_re;
  logic [EIW-1:0]     stk_waddr, stk_raddr;

  always_ff @(posedge clk_i) begin
    if (id_we) begin
      id_mem[EIW'(in_ei)] <= in_id;
    end
    id_rd_q <= id_mem[id_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tgt_we) begin
      tgt_mem[tgt_waddr] <= in_ti;
    end
    if (tgt_re) begin
      tgt_rd_q <= tgt_mem[tgt_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= {top_node_q, top_next_q};
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_raddr];
    end
  end

  // output register
  logic               out_valid_q;
  logic [NODE_W-1:0]  out_node_q;
  logic               out_has_q;
  status_e            out_st_q;
  logic               out_last_q;
  logic               out_free, out_load, out_load_has;
  logic [NODE_W-1:0]  out_load_node;

  assign out_free = !out_valid_q || m_axis_tready;

  // control side effects
  logic           clr_marks, cnt_clr, cnt_inc;
  logic           mark_set;
  mark_e          mark_val;
  logic [EIW-1:0] mark_idx;

  logic [EIW-1:0] ei_idx, top_idx, v_idx;
  logic [CW-1:0]  top_cnt;
  assign ei_idx  = EIW'(in_ei);
  assign top_idx = EIW'(top_node_q);
  assign v_idx   = EIW'(vnode_q);
  assign top_cnt = dep_cnt_q[top_idx];

  always_comb begin
    state_d    = state_q;
    sp_d       = sp_q;
    failed_d   = failed_q;
    idx_d      = idx_q;
    vnode_d    = vnode_q;
    top_node_d = top_node_q;
    top_next_d = top_next_q;
    req_id_d   = req_id_q;
    st_d       = st_q;
    id_we      = 1'b0;
    id_raddr   = EIW'(idx_q);
    tgt_we     = 1'b0;
    tgt_waddr  = AW'(ei_idx) * AW'(MAX_DEPS) + AW'(dep_cnt_q[ei_idx]);
    tgt_re     = 1'b0;
    tgt_raddr  = AW'(top_idx) * AW'(MAX_DEPS) + AW'(top_next_q);
    stk_we     = 1'b0;
    stk_waddr  = EIW'(sp_q - SPW'(1));
    stk_re     = 1'b0;
    stk_raddr  = EIW'(sp_q - SPW'(2));
    clr_marks  = 1'b0;
    cnt_clr    = 1'b0;
    cnt_inc    = 1'b0;
    mark_set   = 1'b0;
    mark_val   = MARK_DONE;
    mark_idx   = v_idx;
    out_load      = 1'b0;
    out_load_has  = 1'b0;
    out_load_node = top_node_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          st_d    = ST_OK;
          state_d = S_CLOSE;
          unique case (in_op)
            OP_BEGIN: begin
              clr_marks = 1'b1;
              sp_d      = '0;
              failed_d  = 1'b0;
            end
            OP_LOAD: begin
              if ({1'b0, in_ei} >= n_act) begin
                st_d = ST_BAD_INDEX;
              end else begin
                id_we   = 1'b1;
                cnt_clr = 1'b1;
              end
            end
            OP_APPEND: begin
              if ({1'b0, in_ei} >= n_act || {1'b0, in_ti} >= n_act) begin
                st_d = ST_BAD_INDEX;
              end else if (32'(dep_cnt_q[ei_idx]) >= MAX_DEPS) begin
                st_d = ST_FULL;
              end else begin
                tgt_we  = 1'b1;
                cnt_inc = 1'b1;
              end
            end
            OP_REQUEST: begin
              if (failed_q) begin
                st_d = ST_BATCH_FAILED;
              end else if (in_id == '0) begin
                st_d     = ST_INVALID;
                failed_d = 1'b1;
              end else begin
                req_id_d = in_id;
                idx_d    = '0;
                sp_d     = '0;
                state_d  = S_SRCH_ADDR;
              end
            end
            default: ;
          endcase
        end
      end
      S_SRCH_ADDR: begin
        // read issued at idx_q; data arrives next cycle
        if (idx_q >= n_act) begin
          st_d     = ST_NOT_FOUND;
          failed_d = 1'b1;
          state_d  = S_CLOSE;
        end else begin
          state_d = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (id_rd_q == req_id_q) begin
          vnode_d = NODE_W'(idx_q);
          state_d = S_VISIT;
        end else begin
          idx_d   = idx_q + CNT_REG_W'(1);
          state_d = S_SRCH_ADDR;
        end
      end
      S_VISIT: begin
        if ({1'b0, vnode_q} >= n_act) begin
          st_d     = ST_BAD_INDEX;
          failed_d = 1'b1;
          sp_d     = '0;
          state_d  = S_CLOSE;
        end else if (marks_q[v_idx] == MARK_DONE) begin
          state_d = (sp_q == '0) ? S_CLOSE : S_LOOP;
        end else if (marks_q[v_idx] == MARK_VISITING) begin
          st_d     = ST_CYCLE;
          failed_d = 1'b1;
          sp_d     = '0;
          state_d  = S_CLOSE;
        end else begin
          // push: spill current top frame, new node becomes top
          if (sp_q != '0) begin
            stk_we = 1'b1;
          end
          mark_set   = 1'b1;
          mark_val   = MARK_VISITING;
          top_node_d = vnode_q;
          top_next_d = '0;
          sp_d       = sp_q + SPW'(1);
          state_d    = S_LOOP;
        end
      end
      S_LOOP: begin
        if ({1'b0, top_node_q} >= n_act) begin
          st_d     = ST_BAD_INDEX;
          failed_d = 1'b1;
          sp_d     = '0;
          state_d  = S_CLOSE;
        end else if (top_next_q < top_cnt && 32'(top_next_q) < MAX_DEPS) begin
          tgt_re     = 1'b1;
          top_next_d = top_next_q + CW'(1);
          state_d    = S_TGT;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_TGT: begin
        vnode_d = tgt_rd_q;
        state_d = S_VISIT;
      end
      S_EMIT: begin
        // post-order output of the top node, then pop
        if (out_free) begin
          out_load     = 1'b1;
          out_load_has = 1'b1;
          mark_set     = 1'b1;
          mark_val     = MARK_DONE;
          mark_idx     = top_idx;
          sp_d         = sp_q - SPW'(1);
          if (sp_q > SPW'(1)) begin
            stk_re  = 1'b1;
            state_d = S_POP;
          end else begin
            st_d    = ST_OK;
            state_d = S_CLOSE;
          end
        end
      end
      S_POP: begin
        top_node_d = stk_rd_q[FW-1:CW];
        top_next_d = stk_rd_q[CW-1:0];
        state_d    = S_LOOP;
      end
      S_CLOSE: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_has  = 1'b0;
          out_load_node = '0;
          sp_d          = '0;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sp_q     <= '0;
      failed_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sp_q     <= sp_d;
      failed_q <= failed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    vnode_q    <= vnode_d;
    top_node_q <= top_node_d;
    top_next_q <= top_next_d;
    req_id_q   <= req_id_d;
    st_q       <= st_d;
  end

  // dependency counts and visit marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        dep_cnt_q[i] <= '0;
        marks_q[i]   <= MARK_UNVISITED;
      end
    end else begin
      if (cnt_clr) begin
        dep_cnt_q[ei_idx] <= '0;
      end else if (cnt_inc) begin
        dep_cnt_q[ei_idx] <= dep_cnt_q[ei_idx] + CW'(1);
      end
      if (clr_marks) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          marks_q[i] <= MARK_UNVISITED;
        end
      end else if (mark_set) begin
        marks_q[mark_idx] <= mark_val;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_node_q <= out_load_node;
      out_has_q  <= out_load_has;
      out_st_q   <= out_load_has ? ST_OK : st_q;
      out_last_q <= !out_load_has;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_st_q, out_has_q, out_node_q};
  assign m_axis_tlast  = out_last_q;

endmodule
